FILE: rtl/core/fsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

  localparam int BUFFER_COUNT_DEF = 2;
  localparam int BUF_MAX          = 4;
  localparam int IDX_W            = 2;
  localparam int REQ_W            = 2;
  localparam int STATUS_W         = 3;
  localparam int ADDR_W           = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int IN_DATA_W        = 8;
  localparam int OUT_DATA_W       = 40;

  localparam logic [REQ_W-1:0] REQ_VBLANK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SHOW    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PENDING      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ACQUIRED = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load_item;  // latch accepted item, start scan at ring successor
    logic step_scan;  // advance the acquire candidate
    logic commit;     // update state and load the result register
  } fsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_acquire;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } fsc_stat_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [2:0] ring_len);
    logic [2:0] n;
    n = {1'b0, idx} + 3'd1;
    return (n >= ring_len) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/framebuffer_swap_chain.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: an item accepted in IDLE passes the SCAN and WRITE states; WRITE loads the
// result register once it is free. Acquire items stay in SCAN, one ring position
// checked per cycle, until a free buffer is found or the shown buffer is reached.
// One item at a time: the next is accepted after the result register is loaded.
// Reset: synchronous active-low rst_n; buffer zero shown, all flags and base addresses
// cleared, result register empty.
module framebuffer_swap_chain #(
  parameter int BUFFER_COUNT = fsc_pkg::BUFFER_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fsc_pkg::IN_DATA_W-1:0]   in_tdata,  // buffer_index[1:0], zero pad
  input  wire logic [fsc_pkg::REQ_W-1:0]       in_tuser,  // req_type[1:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status[2:0], result_index[4:3], origin_address[36:5], zero pad
  output logic [fsc_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fsc_pkg::ADDR_W-1:0]      cfg_data
);

  fsc_pkg::fsc_cmd_t            cmd;
  fsc_pkg::fsc_stat_t           stat;
  logic [fsc_pkg::STATUS_W-1:0] status;
  logic [fsc_pkg::IDX_W-1:0]    result_index;
  logic [fsc_pkg::ADDR_W-1:0]   origin_address;

  assign cfg_ready = 1'b1;

  fsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsc_datapath #(
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_tuser),
    .in_buffer_index    (in_tdata[fsc_pkg::IDX_W-1:0]),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .stat               (stat),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_status         (status),
    .out_result_index   (result_index),
    .out_origin_address (origin_address)
  );

  assign out_tdata = {3'b000, origin_address, result_index, status};

endmodule

`default_nettype wire

FILE: rtl/core/fsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire fsc_pkg::fsc_stat_t stat,
  output fsc_pkg::fsc_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load_item = 1'b0;
    cmd.step_scan = 1'b0;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        // non-acquire items pass straight through
        if (!stat.is_acquire || stat.scan_hit || stat.scan_end) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.step_scan = 1'b1;
        end
      end
      S_WRITE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fsc_datapath #(
  parameter int BUFFER_COUNT = fsc_pkg::BUFFER_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [fsc_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [fsc_pkg::IDX_W-1:0]       in_buffer_index,
  input  wire logic                            cfg_valid,
  input  wire logic [fsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fsc_pkg::ADDR_W-1:0]      cfg_data,
  input  wire fsc_pkg::fsc_cmd_t               cmd,
  output fsc_pkg::fsc_stat_t                   stat,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [fsc_pkg::STATUS_W-1:0]         out_status,
  output logic [fsc_pkg::IDX_W-1:0]            out_result_index,
  output logic [fsc_pkg::ADDR_W-1:0]           out_origin_address
);

  localparam logic [2:0] RING_LEN = 3'(BUFFER_COUNT);

  logic [fsc_pkg::ADDR_W-1:0]  base_r [fsc_pkg::BUF_MAX];
  logic [fsc_pkg::IDX_W-1:0]   shown_r, shown_nxt;
  logic [fsc_pkg::BUF_MAX-1:0] acq_r, acq_nxt;
  logic [fsc_pkg::BUF_MAX-1:0] pend_r, pend_nxt;
  logic [fsc_pkg::REQ_W-1:0]   req_r;
  logic [fsc_pkg::IDX_W-1:0]   idx_r;
  logic [fsc_pkg::IDX_W-1:0]   cand_r;
  logic                        out_valid_r;
  logic [fsc_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [fsc_pkg::IDX_W-1:0]   res_idx_r, res_idx_nxt;
  logic [fsc_pkg::ADDR_W-1:0]  origin_r, origin_nxt;
  logic [fsc_pkg::IDX_W-1:0]   vb_next;
  logic [fsc_pkg::BUF_MAX-1:0] cand_mask, idx_mask, vb_mask;

  assign cand_mask = 4'b0001 << cand_r;
  assign idx_mask  = 4'b0001 << idx_r;
  assign vb_next   = fsc_pkg::ring_next(shown_r, RING_LEN);
  assign vb_mask   = 4'b0001 << vb_next;

  assign stat.is_acquire = (req_r == fsc_pkg::REQ_ACQUIRE);
  assign stat.scan_end   = (cand_r == shown_r);
  assign stat.scan_hit   = (cand_r != shown_r) && (((acq_r | pend_r) & cand_mask) == '0);
  assign stat.out_free   = !out_valid_r || out_tready;

  always_comb begin
    shown_nxt   = shown_r;
    acq_nxt     = acq_r;
    pend_nxt    = pend_r;
    status_nxt  = fsc_pkg::ST_OK;
    res_idx_nxt = '0;
    origin_nxt  = '0;
    case (req_r)
      fsc_pkg::REQ_VBLANK: begin
        // advance only onto a pending buffer
        if ((pend_r & vb_mask) != '0) begin
          shown_nxt = vb_next;
          pend_nxt  = pend_r & ~vb_mask;
        end
        res_idx_nxt = shown_nxt;
        origin_nxt  = base_r[shown_nxt];
      end
      fsc_pkg::REQ_ACQUIRE: begin
        if (stat.scan_hit) begin
          acq_nxt     = acq_r | cand_mask;
          res_idx_nxt = cand_r;
        end else begin
          status_nxt = fsc_pkg::ST_NO_FREE;
        end
      end
      fsc_pkg::REQ_SHOW: begin
        res_idx_nxt = idx_r;
        if ({1'b0, idx_r} >= RING_LEN) begin
          status_nxt = fsc_pkg::ST_BAD_INDEX;
        end else if ((pend_r & idx_mask) != '0) begin
          status_nxt = fsc_pkg::ST_PENDING;
        end else if ((acq_r & idx_mask) == '0) begin
          status_nxt = fsc_pkg::ST_NOT_ACQUIRED;
        end else begin
          acq_nxt  = acq_r & ~idx_mask;
          pend_nxt = pend_r | idx_mask;
        end
      end
      default: res_idx_nxt = shown_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsc_pkg::BUF_MAX; i++) begin
        base_r[i] <= '0;
      end
    end else if (cfg_valid && (cfg_index < 3'(fsc_pkg::BUF_MAX))) begin
      base_r[cfg_index[fsc_pkg::IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= '0;
      acq_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        shown_r     <= shown_nxt;
        acq_r       <= acq_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r  <= in_req_type;
      idx_r  <= in_buffer_index;
      cand_r <= fsc_pkg::ring_next(shown_r, RING_LEN);
    end else if (cmd.step_scan) begin
      cand_r <= fsc_pkg::ring_next(cand_r, RING_LEN);
    end
    if (cmd.commit) begin
      status_r  <= status_nxt;
      res_idx_r <= res_idx_nxt;
      origin_r  <= origin_nxt;
    end
  end

  assign out_tvalid         = out_valid_r;
  assign out_status         = status_r;
  assign out_result_index   = res_idx_r;
  assign out_origin_address = origin_r;

endmodule

`default_nettype wire
